>>> src/sqcr_pkg.sv
// ----------------------------------------------------------------------------
// sqcr_pkg
// Types, constants and tables shared by the sprite quad corner rotate block.
// ----------------------------------------------------------------------------
package sqcr_pkg;

	localparam int CordicSteps = 16;
	localparam int QueueDepth  = 4;
	localparam int QPtrW       = $clog2(QueueDepth);

	localparam logic signed [18:0] CORDIC_START = 19'sd39797;
	localparam logic signed [18:0] UNIT_POS     = 19'sd65536;
	localparam logic signed [18:0] UNIT_NEG     = -19'sd65536;
	localparam logic signed [44:0] ROUND_HALF   = 45'sd32768;
	localparam logic signed [44:0] POS_MAX      = 45'sd8388607;
	localparam logic signed [44:0] POS_MIN      = -45'sd8388608;

	typedef enum logic [1:0] {
		CORNER_TR = 2'd0,
		CORNER_TL = 2'd1,
		CORNER_BL = 2'd2,
		CORNER_BR = 2'd3
	} corner_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// sprite fields that ride along the rotation pipeline
	typedef struct packed {
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic [15:0]        ul;
		logic [15:0]        ub;
		logic [15:0]        ur;
		logic [15:0]        vt;
		logic [31:0]        rgba;
		quad_t              quad;
		logic               zero_res;
	} front_pl_t;

	// one classified sprite, as queued between front and back
	typedef struct packed {
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic signed [17:0] c;
		logic signed [17:0] s;
		logic [15:0]        ul;
		logic [15:0]        ub;
		logic [15:0]        ur;
		logic [15:0]        vt;
		logic [31:0]        rgba;
	} sprite_rec_t;

	// arctangent of 2^-i in 1/65536 turns
	function automatic logic [13:0] atan_turns(input int i);
		logic [13:0] a;
		case (i)
			0:       a = 14'd8192;
			1:       a = 14'd4836;
			2:       a = 14'd2555;
			3:       a = 14'd1297;
			4:       a = 14'd651;
			5:       a = 14'd326;
			6:       a = 14'd163;
			7:       a = 14'd81;
			8:       a = 14'd41;
			9:       a = 14'd20;
			10:      a = 14'd10;
			11:      a = 14'd5;
			12:      a = 14'd3;
			13:      a = 14'd1;
			14:      a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

endpackage

>>> src/sqcr_in_if.sv
// ----------------------------------------------------------------------------
// sqcr_in_if
// Sprite request channel: valid/ready handshake with the sprite fields.
// ----------------------------------------------------------------------------
interface sqcr_in_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] size_x;
	logic signed [23:0] size_y;
	logic signed [23:0] pivot_x;
	logic signed [23:0] pivot_y;
	logic [15:0]        angle_turns;
	logic [15:0]        uv_left;
	logic [15:0]        uv_bottom;
	logic [15:0]        uv_width;
	logic [15:0]        uv_height;
	logic [31:0]        rgba;

	modport source (output valid, pos_x, pos_y, size_x, size_y, pivot_x, pivot_y,
		angle_turns, uv_left, uv_bottom, uv_width, uv_height, rgba, input ready);
	modport sink (input valid, pos_x, pos_y, size_x, size_y, pivot_x, pivot_y,
		angle_turns, uv_left, uv_bottom, uv_width, uv_height, rgba, output ready);
endinterface

>>> src/sqcr_out_if.sv
// ----------------------------------------------------------------------------
// sqcr_out_if
// Vertex request channel: valid/ready handshake with the vertex fields.
// ----------------------------------------------------------------------------
interface sqcr_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] vert_x;
	logic signed [23:0] vert_y;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic [31:0]        vert_rgba;
	logic [1:0]         corner_index;
	logic               last_corner;

	modport source (output valid, vert_x, vert_y, tex_u, tex_v, vert_rgba,
		corner_index, last_corner, input ready);
	modport sink (input valid, vert_x, vert_y, tex_u, tex_v, vert_rgba,
		corner_index, last_corner, output ready);
endinterface

>>> src/sqcr_front.sv
// ----------------------------------------------------------------------------
// sqcr_front
// Accepts sprites, forms corner bases and UV extents, and runs a 16-stage
// pipelined CORDIC for the cosine and sine of the angle.
// ----------------------------------------------------------------------------
module sqcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	sqcr_in_if.sink              sprite,
	input  logic                 q_full,
	output logic                 push,
	output sqcr_pkg::sprite_rec_t push_rec
);
	import sqcr_pkg::*;

	logic               v_q  [0:CordicSteps];
	logic signed [18:0] x_q  [0:CordicSteps];
	logic signed [18:0] y_q  [0:CordicSteps];
	logic signed [16:0] z_q  [0:CordicSteps];
	front_pl_t          pl_q [0:CordicSteps];
	logic               en;
	logic [16:0]        u_sum;
	logic [16:0]        v_sum;
	logic signed [17:0] cr;
	logic signed [17:0] sr;
	logic signed [17:0] c_w;
	logic signed [17:0] s_w;
	front_pl_t          pl_last;

	// advance everything unless the last stage holds a sprite the queue cannot take
	assign en           = !v_q[CordicSteps] || !q_full;
	assign sprite.ready = en;
	assign push         = v_q[CordicSteps] && !q_full;

	assign u_sum = {1'b0, sprite.uv_left} + {1'b0, sprite.uv_width};
	assign v_sum = {1'b0, sprite.uv_bottom} + {1'b0, sprite.uv_height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= sprite.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]           <= CORDIC_START;
			y_q[0]           <= '0;
			z_q[0]           <= {3'b000, sprite.angle_turns[13:0]};
			pl_q[0].dx       <= 25'(sprite.pos_x) - 25'(sprite.pivot_x);
			pl_q[0].dy       <= 25'(sprite.pos_y) - 25'(sprite.pivot_y);
			pl_q[0].sx       <= sprite.size_x;
			pl_q[0].sy       <= sprite.size_y;
			pl_q[0].ul       <= sprite.uv_left;
			pl_q[0].ub       <= sprite.uv_bottom;
			pl_q[0].ur       <= u_sum[16] ? 16'hFFFF : u_sum[15:0];
			pl_q[0].vt       <= v_sum[16] ? 16'hFFFF : v_sum[15:0];
			pl_q[0].rgba     <= sprite.rgba;
			pl_q[0].quad     <= quad_t'(sprite.angle_turns[15:14]);
			pl_q[0].zero_res <= (sprite.angle_turns[13:0] == 14'd0);
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		logic signed [16:0] at;
		assign at = $signed({3'b000, atan_turns(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_q[i+1] <= pl_q[i];
				if (!z_q[i][16]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - at;
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + at;
				end
			end
		end
	end

	assign pl_last = pl_q[CordicSteps];

	// clamp to one unit; a zero residue is exact
	always_comb begin
		if (pl_last.zero_res) begin
			cr = 18'(UNIT_POS);
			sr = '0;
		end else begin
			if (x_q[CordicSteps] > UNIT_POS)      cr = 18'(UNIT_POS);
			else if (x_q[CordicSteps] < UNIT_NEG) cr = 18'(UNIT_NEG);
			else                                   cr = x_q[CordicSteps][17:0];
			if (y_q[CordicSteps] > UNIT_POS)      sr = 18'(UNIT_POS);
			else if (y_q[CordicSteps] < UNIT_NEG) sr = 18'(UNIT_NEG);
			else                                   sr = y_q[CordicSteps][17:0];
		end
	end

	always_comb begin
		unique case (pl_last.quad)
			QUAD_0: begin c_w = cr;  s_w = sr;  end
			QUAD_1: begin c_w = -sr; s_w = cr;  end
			QUAD_2: begin c_w = -cr; s_w = -sr; end
			QUAD_3: begin c_w = sr;  s_w = -cr; end
			default: begin c_w = cr; s_w = sr;  end
		endcase
	end

	always_comb begin
		push_rec.dx   = pl_last.dx;
		push_rec.dy   = pl_last.dy;
		push_rec.sx   = pl_last.sx;
		push_rec.sy   = pl_last.sy;
		push_rec.c    = c_w;
		push_rec.s    = s_w;
		push_rec.ul   = pl_last.ul;
		push_rec.ub   = pl_last.ub;
		push_rec.ur   = pl_last.ur;
		push_rec.vt   = pl_last.vt;
		push_rec.rgba = pl_last.rgba;
	end

endmodule

>>> src/sqcr_fifo.sv
// ----------------------------------------------------------------------------
// sqcr_fifo
// Short queue of classified sprites between the front and the back.
// ----------------------------------------------------------------------------
module sqcr_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sqcr_pkg::sprite_rec_t push_rec,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output sqcr_pkg::sprite_rec_t head
);
	import sqcr_pkg::*;

	sprite_rec_t      mem_q [0:QueueDepth-1];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QPtrW:0]   cnt_q;

	assign full      = (cnt_q == (QPtrW+1)'(QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPtrW+1)'(QueueDepth)) else $error("queue count out of range");

endmodule

>>> src/sqcr_back.sv
// ----------------------------------------------------------------------------
// sqcr_back
// Expands each queued sprite into four corners, rotates, rounds and
// saturates in three registered stages; one vertex per cycle unless stalled.
// ----------------------------------------------------------------------------
module sqcr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  sqcr_pkg::sprite_rec_t head,
	output logic                  pop,
	sqcr_out_if.source            vertex
);
	import sqcr_pkg::*;

	logic               en;
	corner_t            k_q;
	logic               right;
	logic               top;

	logic               v_s1, v_s2, v_s3;
	logic signed [25:0] x_s1, y_s1;
	logic signed [17:0] c_s1, s_s1;
	logic [15:0]        u_s1, t_s1, u_s2, t_s2;
	logic [31:0]        rgba_s1, rgba_s2;
	corner_t            k_s1, k_s2;
	logic signed [43:0] xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [44:0] rx_w, ry_w;

	assign en    = !v_s3 || vertex.ready;
	assign pop   = en && q_valid && (k_q == CORNER_BR);
	assign right = (k_q == CORNER_TR) || (k_q == CORNER_BR);
	assign top   = (k_q == CORNER_TR) || (k_q == CORNER_TL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= CORNER_TR;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (q_valid) k_q <= corner_t'(k_q + 2'd1);
		end
	end

	// corner select
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= 26'(head.dx) + (right ? 26'(head.sx) : 26'sd0);
			y_s1    <= 26'(head.dy) + (top ? 26'(head.sy) : 26'sd0);
			c_s1    <= head.c;
			s_s1    <= head.s;
			u_s1    <= right ? head.ur : head.ul;
			t_s1    <= top ? head.vt : head.ub;
			rgba_s1 <= head.rgba;
			k_s1    <= k_q;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			xc_s2   <= x_s1 * c_s1;
			ys_s2   <= y_s1 * s_s1;
			xs_s2   <= x_s1 * s_s1;
			yc_s2   <= y_s1 * c_s1;
			u_s2    <= u_s1;
			t_s2    <= t_s1;
			rgba_s2 <= rgba_s1;
			k_s2    <= k_s1;
		end
	end

	assign rx_w = (45'(xc_s2) - 45'(ys_s2) + ROUND_HALF) >>> 16;
	assign ry_w = (45'(xs_s2) + 45'(yc_s2) + ROUND_HALF) >>> 16;

	// round, saturate, hold for the receiver
	always_ff @(posedge clk) begin
		if (en) begin
			if (rx_w > POS_MAX)      vertex.vert_x <= 24'(POS_MAX);
			else if (rx_w < POS_MIN) vertex.vert_x <= 24'(POS_MIN);
			else                     vertex.vert_x <= rx_w[23:0];
			if (ry_w > POS_MAX)      vertex.vert_y <= 24'(POS_MAX);
			else if (ry_w < POS_MIN) vertex.vert_y <= 24'(POS_MIN);
			else                     vertex.vert_y <= ry_w[23:0];
			vertex.tex_u        <= u_s2;
			vertex.tex_v        <= t_s2;
			vertex.vert_rgba    <= rgba_s2;
			vertex.corner_index <= k_s2;
			vertex.last_corner  <= (k_s2 == CORNER_BR);
		end
	end

	assign vertex.valid = v_s3;

	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1) |=> (k_s2 == $past(k_s1))) else $error("corner lost in pipe");
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(en && q_valid && (k_q == CORNER_BR)) |=> (k_q == CORNER_TR))
		else $error("corner counter did not wrap");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid |-> (vertex.last_corner == (vertex.corner_index == CORNER_BR)))
		else $error("last flag off corner three");

endmodule

>>> src/sprite_quad_corner_rotate.sv
// ----------------------------------------------------------------------------
// sprite_quad_corner_rotate
// Sprite quad vertex setup with rotation, Q15.8 positions, Q1.15 UVs.
// ----------------------------------------------------------------------------
// Usage:
//   sprite is the input channel: one request carries one sprite (position,
//   size, pivot, angle in 1/65536 turns, UV rectangle, color).
//   vertex is the output channel: four requests per sprite, in the order
//   top-right, top-left, bottom-left, bottom-right; last_corner marks the
//   fourth.
//   Path: a sprite passes one input register, 16 CORDIC stages, the
//   sprite queue and three vertex stages before its first vertex shows.
//   Throughput is set by the single vertex port, four vertices per
//   sprite; the front takes a sprite every cycle until the 4-entry
//   sprite queue is full and the last CORDIC stage is busy.
//   A stalled receiver holds the vertex register and the vertex stages;
//   ready drops when the queue is full and the last CORDIC stage is busy.
//   Reset clears all valid flags, pointers and the corner counter; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_quad_corner_rotate (
	input  logic       clk,
	input  logic       arst_n,
	sqcr_in_if.sink    sprite,
	sqcr_out_if.source vertex
);
	import sqcr_pkg::*;

	logic        q_full;
	logic        push;
	logic        pop;
	logic        q_valid;
	sprite_rec_t push_rec;
	sprite_rec_t head;

	sqcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sprite   (sprite),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	sqcr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	sqcr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.vertex  (vertex)
	);

endmodule
